/* rtl/differential_drive_odometry_macros.svh */
// Assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDO_ASSERT(lbl, prop, msg)
`define DDO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/ddo_pkg.sv */
`default_nettype none
package ddo_pkg;

  localparam int MUL_W = 40;
  localparam int DIV_W = 64;

  localparam logic [33:0] GAIN_Q30 = 34'd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
  localparam logic [39:0] INV_TWO_PI_Q29 = 40'd85445659;
  localparam logic signed [65:0] POS_MAX = 66'sd549755813887;
  localparam logic signed [65:0] POS_MIN = -66'sd549755813888;

  localparam logic [15:0] AXLE_WIDTH_RST = 16'd34304;
  localparam logic [23:0] DIST_PER_TICK_RST = 24'd2662242;

  typedef enum logic {
    CFG_AXLE_WIDTH    = 1'b0,
    CFG_DIST_PER_TICK = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CORD1, S_MULD, S_MULX, S_MULY, S_MULT, S_DIVQ, S_DIVM,
    S_MULB, S_CORD2, S_MULS, S_MULNX, S_DIVX, S_MULNY, S_DIVY, S_FIN
  } state_t;

  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic cord_start;
  } unit_start_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [32:0] t;
    t = v[31] ? 33'd0 - {v[31], v} : {v[31], v};
    return t[31:0];
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? 33'd0 - v : v;
    return t[31:0];
  endfunction

  function automatic logic signed [64:0] apply_sign(input logic [63:0] m, input logic neg);
    logic [64:0] t;
    t = {1'b0, m};
    return neg ? -$signed(t) : $signed(t);
  endfunction

endpackage
`default_nettype wire

/* rtl/ddo_mul.sv */
`default_nettype none
module ddo_mul (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  input  wire logic [ddo_pkg::MUL_W-1:0]                  a,
  input  wire logic [ddo_pkg::MUL_W-1:0]                  b,
  output logic                                            done,
  output logic [2*ddo_pkg::MUL_W-1:0]                     prod
);
  import ddo_pkg::*;

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0] a_r, hi_r, lo_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      lo_r <= b;
      hi_r <= '0;
    end else if (busy_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule
`default_nettype wire

/* rtl/ddo_div.sv */
`default_nettype none
module ddo_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ddo_pkg::DIV_W-1:0]    num,
  input  wire logic [ddo_pkg::DIV_W-1:0]    den,
  output logic                              done,
  output logic [ddo_pkg::DIV_W-1:0]         quot,
  output logic [ddo_pkg::DIV_W-1:0]         rem
);
  import ddo_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] d_r, q_r, rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= den;
      q_r   <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* rtl/ddo_cordic.sv */
`default_nettype none
module ddo_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    done,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  import ddo_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x_r, y_r, z_r, xs, ys, at, xc, yc;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r, flip_r;
  logic               flip;
  logic [31:0]        ang_f, ang_off;

  assign ang_off = angle + 32'h4000_0000;
  assign flip    = ang_off[31];
  assign ang_f   = flip ? (angle ^ 32'h8000_0000) : angle;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = $signed({2'b00, atan_turn(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x_r    <= $signed(GAIN_Q30);
      y_r    <= '0;
      z_r    <= $signed({{2{ang_f[31]}}, ang_f});
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  always_comb begin
    xc = x_r;
    yc = y_r;
    if (x_r > ONE_Q30) xc = ONE_Q30;
    if (x_r < -ONE_Q30) xc = -ONE_Q30;
    if (y_r > ONE_Q30) yc = ONE_Q30;
    if (y_r < -ONE_Q30) yc = -ONE_Q30;
    if (flip_r) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_o = xc[31:0];
  assign sin_o = yc[31:0];
  assign done  = done_r;

endmodule
`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// Channel   | Direction | Handshake             | Payload
// in        | input     | in_valid / in_ready   | in_left_ticks, in_right_ticks
// out       | output    | out_valid / out_ready | out_pos_x, out_pos_y, out_heading
// cfg       | input     | cfg_we                | cfg_index, cfg_data
//
// One item is worked on at a time. Straight motion needs no divider; an arc also uses
// the divider and a second CORDIC rotation. The multiplier and divider are bit-serial.
// Reset clears the pose and loads the default geometry.
// A result waiting on out_ready holds the pose update of the next item at its last step.
`default_nettype none
module differential_drive_odometry #(
  parameter int POS_FRAC_BITS = 16,
  parameter int CORDIC_STEPS  = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_left_ticks,
  input  wire logic signed [15:0] in_right_ticks,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [39:0]      out_pos_x,
  output logic signed [39:0]      out_pos_y,
  output logic [31:0]             out_heading,
  input  wire logic               cfg_we,
  input  wire ddo_pkg::cfg_idx_t  cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import ddo_pkg::*;

  localparam int ST_SH  = 54 - POS_FRAC_BITS;
  localparam int DEN_SH = 38 - POS_FRAC_BITS;

  state_t state_r, state_nxt;
  unit_start_t starts;
  logic launch_r;

  logic [15:0] aw_r;
  logic [23:0] dpt_r;
  logic signed [15:0] l_r, r_r;
  logic signed [31:0] c1_r, s1_r, c2_r, s2_r;
  logic [63:0] acc_r, num_r;
  logic [31:0] h2_r, heading_r;
  logic signed [64:0] dx_r, dy_r;
  logic signed [39:0] pose_x_r, pose_y_r, out_x_r, out_y_r;
  logic [31:0] out_h_r;
  logic out_valid_r;

  logic signed [16:0] diff, sum;
  logic [16:0] diff_abs, sum_abs, r_abs;
  logic [15:0] aw_eff;
  logic signed [32:0] sd, cd;
  logic diff_zero, commit;
  logic [63:0] den_half, den;

  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] prod, prod_st, prod_ba;
  logic mul_done, div_done, cord_done;
  logic [DIV_W-1:0] div_n, div_d, quot, rem;
  logic [31:0] cord_ang, ba;
  logic signed [31:0] cos_v, sin_v;
  logic signed [65:0] px_sum, py_sum;
  logic signed [39:0] px_nxt, py_nxt;

  assign diff      = r_r - l_r;
  assign sum       = r_r + l_r;
  assign diff_abs  = diff[16] ? 17'd0 - diff : diff;
  assign sum_abs   = sum[16] ? 17'd0 - sum : sum;
  assign r_abs     = r_r[15] ? 17'd0 - {r_r[15], r_r} : {r_r[15], r_r};
  assign diff_zero = diff == 17'sd0;
  assign aw_eff    = (aw_r == 16'd0) ? 16'd1 : aw_r;
  assign sd        = {s2_r[31], s2_r} - {s1_r[31], s1_r};
  assign cd        = {c1_r[31], c1_r} - {c2_r[31], c2_r};
  assign den_half  = 64'(diff_abs[15:0]) << DEN_SH;
  assign den       = den_half << 1;
  assign commit    = !out_valid_r || out_ready;
  assign prod_st   = (prod + ((2*MUL_W)'(1) << (ST_SH - 1))) >> ST_SH;
  assign prod_ba   = (prod + ((2*MUL_W)'(1) << 28)) >> 29;
  assign ba        = prod_ba[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MULD: begin
        mul_a = MUL_W'(r_abs);
        mul_b = MUL_W'(dpt_r);
      end
      S_MULX: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(abs32(c1_r));
      end
      S_MULY: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(abs32(s1_r));
      end
      S_MULT: begin
        mul_a = MUL_W'(diff_abs);
        mul_b = MUL_W'(dpt_r);
      end
      S_MULB: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = INV_TWO_PI_Q29;
      end
      S_MULS: begin
        mul_a = MUL_W'(sum_abs);
        mul_b = MUL_W'(aw_eff);
      end
      S_MULNX: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(abs33(sd));
      end
      S_MULNY: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(abs33(cd));
      end
      default: ;
    endcase
  end

  always_comb begin
    div_n = num_r + den_half;
    div_d = den;
    case (state_r)
      S_DIVQ: begin
        div_n = {acc_r[47:0], 16'd0} + 64'(aw_eff[15:1]);
        div_d = 64'(aw_eff);
      end
      S_DIVM: begin
        div_n = acc_r;
        div_d = TWO_PI_Q32;
      end
      default: ;
    endcase
  end

  assign cord_ang = (state_r == S_CORD2) ? h2_r : heading_r;

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (starts.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (starts.div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (quot),
    .rem   (rem)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (starts.cord_start),
    .angle (cord_ang),
    .done  (cord_done),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CORD1;
      S_CORD1: if (cord_done) state_nxt = diff_zero ? S_MULD : S_MULT;
      S_MULD:  if (mul_done) state_nxt = S_MULX;
      S_MULX:  if (mul_done) state_nxt = S_MULY;
      S_MULY:  if (mul_done) state_nxt = S_FIN;
      S_MULT:  if (mul_done) state_nxt = S_DIVQ;
      S_DIVQ:  if (div_done) state_nxt = S_DIVM;
      S_DIVM:  if (div_done) state_nxt = S_MULB;
      S_MULB:  if (mul_done) state_nxt = S_CORD2;
      S_CORD2: if (cord_done) state_nxt = S_MULS;
      S_MULS:  if (mul_done) state_nxt = S_MULNX;
      S_MULNX: if (mul_done) state_nxt = S_DIVX;
      S_DIVX:  if (div_done) state_nxt = S_MULNY;
      S_MULNY: if (mul_done) state_nxt = S_DIVY;
      S_DIVY:  if (div_done) state_nxt = S_FIN;
      S_FIN:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    starts   = '0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CORD1, S_CORD2: starts.cord_start = launch_r;
      S_DIVQ, S_DIVM, S_DIVX, S_DIVY: starts.div_start = launch_r;
      S_MULD, S_MULX, S_MULY, S_MULT, S_MULB, S_MULS, S_MULNX, S_MULNY:
        starts.mul_start = launch_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r) && (state_nxt != S_IDLE) && (state_nxt != S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r  <= AXLE_WIDTH_RST;
      dpt_r <= DIST_PER_TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AXLE_WIDTH:    aw_r  <= cfg_data[15:0];
        CFG_DIST_PER_TICK: dpt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      l_r <= in_left_ticks;
      r_r <= in_right_ticks;
    end
    case (state_r)
      S_CORD1: if (cord_done) begin
        c1_r <= cos_v;
        s1_r <= sin_v;
        dx_r <= '0;
        dy_r <= '0;
      end
      S_CORD2: if (cord_done) begin
        c2_r <= cos_v;
        s2_r <= sin_v;
      end
      S_MULD, S_MULT, S_MULS: if (mul_done) acc_r <= prod[63:0];
      S_MULX: if (mul_done) dx_r <= apply_sign(prod_st[63:0], r_r[15] ^ c1_r[31]);
      S_MULY: if (mul_done) dy_r <= apply_sign(prod_st[63:0], r_r[15] ^ s1_r[31]);
      S_DIVQ: if (div_done) acc_r <= quot;
      S_DIVM: if (div_done) acc_r <= rem;
      S_MULB: if (mul_done) h2_r <= heading_r + (diff[16] ? 32'd0 - ba : ba);
      S_MULNX, S_MULNY: if (mul_done) num_r <= prod[63:0];
      S_DIVX: if (div_done) dx_r <= apply_sign(quot, sum[16] ^ sd[32] ^ diff[16]);
      S_DIVY: if (div_done) dy_r <= apply_sign(quot, sum[16] ^ cd[32] ^ diff[16]);
      default: ;
    endcase
  end

  assign px_sum = {{26{pose_x_r[39]}}, pose_x_r} + {dx_r[64], dx_r};
  assign py_sum = {{26{pose_y_r[39]}}, pose_y_r} + {dy_r[64], dy_r};
  assign px_nxt = (px_sum > POS_MAX) ? POS_MAX[39:0] :
                  (px_sum < POS_MIN) ? POS_MIN[39:0] : px_sum[39:0];
  assign py_nxt = (py_sum > POS_MAX) ? POS_MAX[39:0] :
                  (py_sum < POS_MIN) ? POS_MIN[39:0] : py_sum[39:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && commit) begin
        pose_x_r    <= px_nxt;
        pose_y_r    <= py_nxt;
        out_valid_r <= 1'b1;
        if (!diff_zero) heading_r <= h2_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && commit) begin
      out_x_r <= px_nxt;
      out_y_r <= py_nxt;
      out_h_r <= diff_zero ? heading_r : h2_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_heading = out_h_r;

`include "differential_drive_odometry_macros.svh"

  `DDO_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == S_CORD1), "accepted item did not start")
  `DDO_ASSERT(a_mul_owner, mul_done |-> !(state_r == S_IDLE || state_r == S_FIN), "stray multiplier result")
  `DDO_ASSERT(a_straight_heading, (state_r == S_FIN && commit && diff_zero) |=> (heading_r == $past(heading_r)), "straight move turned")
  `DDO_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset left block busy")

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  import ddo_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam int FRAC = 16;
  localparam int STEPS = 24;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } ticks_t;

  typedef struct {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic [31:0] hdg;
  } pose_t;

  localparam logic [31:0] ATAN_TURN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_left_ticks;
  logic signed [15:0] in_right_ticks;
  logic out_valid;
  logic out_ready;
  logic signed [39:0] out_pos_x;
  logic signed [39:0] out_pos_y;
  logic [31:0] out_heading;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [23:0] cfg_data;

  ticks_t pending_ticks[$];
  pose_t expected_poses[$];
  int errors;
  longint cycles;
  bit took_item;
  bit quiet;
  int send_gap;
  int recv_gap;
  int long_hold;

  longint unsigned axle_w;
  longint unsigned dist_tick;
  longint pose_x;
  longint pose_y;
  logic [31:0] heading_acc;

  differential_drive_odometry u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_ticks(in_left_ticks), .in_right_ticks(in_right_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint unsigned mul_shift_round(input longint unsigned a,
                                                     input longint unsigned b, input int s);
    longint unsigned t;
    t = a * (b >> 15) + ((a * (b & 64'h7FFF)) >> 15) + (64'd1 << (s - 16));
    return t >> (s - 15);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint cosv, output longint sinv);
    logic [31:0] a;
    logic [31:0] probe;
    bit flip;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    a = ang;
    probe = a + 32'h40000000;
    flip = probe[31];
    if (flip) a = a ^ 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> (i % 32);
      ys = y >>> (i % 32);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN[i % 32]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN[i % 32]);
      end
    end
    if (x > 1073741824) x = 1073741824;
    if (x < -1073741824) x = -1073741824;
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    cosv = flip ? -x : x;
    sinv = flip ? -y : y;
  endtask

  function automatic longint line_step(input longint d, input longint trig);
    longint unsigned m;
    m = mul_shift_round(magnitude(d), magnitude(trig), 54 - FRAC);
    return ((d < 0) != (trig < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint arc_step(input longint sum, input longint unsigned aw,
                                      input longint sd, input longint diff);
    longint unsigned n;
    longint unsigned den;
    longint unsigned m;
    bit neg;
    neg = ((sum < 0) != (sd < 0)) != (diff < 0);
    n = magnitude(sum) * aw * magnitude(sd);
    den = (64'd2 * magnitude(diff)) << (38 - FRAC);
    m = (n + den / 2) / den;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  task automatic advance_pose(input logic signed [15:0] lt, input logic signed [15:0] rt);
    longint l;
    longint r;
    longint diff;
    longint sum;
    longint dx;
    longint dy;
    longint c1;
    longint s1;
    longint c2;
    longint s2;
    longint num;
    longint unsigned aw;
    longint unsigned q;
    longint unsigned m;
    logic [63:0] scaled;
    logic [31:0] turn;
    logic [31:0] h2;
    pose_t p;
    l = lt;
    r = rt;
    aw = axle_w == 0 ? 64'd1 : axle_w;
    diff = r - l;
    sum = r + l;
    rotate(heading_acc, c1, s1);
    if (diff == 0) begin
      dx = line_step(r * longint'(dist_tick), c1);
      dy = line_step(r * longint'(dist_tick), s1);
    end else begin
      num = diff * longint'(dist_tick);
      q = ((magnitude(num) << 16) + aw / 2) / aw;
      m = q % 64'd26986075409;
      scaled = (m * 64'd85445659 + (64'd1 << 28)) >> 29;
      turn = num < 0 ? 32'd0 - scaled[31:0] : scaled[31:0];
      h2 = heading_acc + turn;
      rotate(h2, c2, s2);
      dx = arc_step(sum, aw, s2 - s1, diff);
      dy = arc_step(sum, aw, c1 - c2, diff);
      heading_acc = h2;
    end
    pose_x = clamp_pos(pose_x + dx);
    pose_y = clamp_pos(pose_y + dy);
    p.x = pose_x[39:0];
    p.y = pose_y[39:0];
    p.hdg = heading_acc;
    expected_poses.push_back(p);
  endtask

  task automatic report(input string field, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      advance_pose(in_left_ticks, in_right_ticks);
      void'(pending_ticks.pop_front());
      took_item = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !took_item)) begin
      took_item = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        in_valid <= 1'b1;
        in_left_ticks <= pending_ticks[0].left;
        in_right_ticks <= pending_ticks[0].right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        $display("result with no item outstanding");
        errors++;
      end else begin
        if (out_pos_x !== expected_poses[0].x) report("pos_x", out_pos_x, expected_poses[0].x);
        if (out_pos_y !== expected_poses[0].y) report("pos_y", out_pos_y, expected_poses[0].y);
        if (out_heading !== expected_poses[0].hdg)
          report("heading", 40'(out_heading), 40'(expected_poses[0].hdg));
        void'(expected_poses.pop_front());
      end
    end
  end

  task automatic add_ticks(input int l, input int r);
    ticks_t t;
    t.left = 16'(l);
    t.right = 16'(r);
    pending_ticks.push_back(t);
  endtask

  task automatic add_random_ticks();
    int l;
    int d;
    l = $signed(16'($urandom));
    case ($urandom_range(0, 9))
      0, 1, 2: add_ticks(l, l);
      3, 4, 5: begin
        l = $urandom_range(0, 400) - 200;
        d = $urandom_range(0, 60) - 30;
        add_ticks(l, l + d);
      end
      6, 7: add_ticks($signed(16'($urandom)), $signed(16'($urandom)));
      8: add_ticks($urandom_range(0, 1) ? 32767 : -32768, $urandom_range(0, 1) ? 32767 : -32768);
      default: add_ticks(l, (l == 32767) ? l - 1 : l + 1);
    endcase
  endtask

  task automatic drain();
    wait (pending_ticks.size() == 0 && expected_poses.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AXLE_WIDTH) axle_w = value[15:0];
    else dist_tick = value;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    took_item = 1'b0;
    quiet = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    long_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_left_ticks = '0;
    in_right_ticks = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_AXLE_WIDTH;
    cfg_data = '0;
    axle_w = 34304;
    dist_tick = 2662242;
    pose_x = 0;
    pose_y = 0;
    heading_acc = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_ticks(0, 0);
    add_ticks(32767, 32767);
    add_ticks(-32768, -32768);
    add_ticks(-32768, 32767);
    add_ticks(32767, -32768);
    add_ticks(1, -1);
    add_ticks(-1, 1);
    add_ticks(100, 100);
    add_ticks(5, -5);
    add_ticks(0, 1);
    add_ticks(1, 0);
    add_ticks(-200, 300);
    add_ticks(32767, 32766);
    add_ticks(-32768, -32767);
    add_ticks(0, 32767);
    add_ticks(-32768, 0);
    add_ticks(50, 150);
    add_ticks(-7, -7);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_AXLE_WIDTH, 24'd65535);
          write_reg(CFG_DIST_PER_TICK, 24'hFFFFFF);
        end
        1: begin
          write_reg(CFG_AXLE_WIDTH, 24'd1);
          write_reg(CFG_DIST_PER_TICK, 24'd1);
        end
        2: begin
          write_reg(CFG_AXLE_WIDTH, 24'd0);
          write_reg(CFG_DIST_PER_TICK, 24'd2662242);
        end
        3: begin
          write_reg(CFG_AXLE_WIDTH, 24'($urandom_range(1, 65535)));
          write_reg(CFG_DIST_PER_TICK, 24'd0);
        end
        4: begin
          write_reg(CFG_AXLE_WIDTH, 24'd34304);
          write_reg(CFG_DIST_PER_TICK, 24'd2662242);
        end
        default: begin
          write_reg(CFG_AXLE_WIDTH, 24'($urandom_range(1, 65535)));
          write_reg(CFG_DIST_PER_TICK, 24'($urandom_range(1, 16777215)));
        end
      endcase
      if (ph == 6) quiet = 1'b1;
      if (ph == 0) begin
        for (int i = 0; i < 400; i++) begin
          if (i < 200) add_ticks(32767, 32767);
          else add_ticks(-32768, -32768);
        end
      end
      if (ph == 2) long_hold = 3000;
      for (int i = 0; i < 215; i++) begin
        add_random_ticks();
        if (ph == 3 && i == 130) drain();
      end
      drain();
    end

    repeat (700) @(posedge clk);
    if (expected_poses.size() != 0) begin
      $display("%0d results never arrived", expected_poses.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
